@@ hw/rtl/tzsm_pkg.sv @@
package tzsm_pkg;

   // Field and register widths
   localparam int SAMPLE_BITS = 10;
   localparam int TIMER_BITS  = 16;
   localparam int CFG_BITS    = 16;
   localparam int LIMIT_BITS  = 10;
   localparam int CSR_IDX_BITS = 2;

   // sample*1000 fits in SAMPLE_BITS + 10 bits, as does limit << SAMPLE_BITS
   localparam int SCALE_BITS  = 10;
   localparam int SCALED_BITS = SAMPLE_BITS + SCALE_BITS;
   localparam logic [SCALE_BITS-1:0] SAMPLE_SCALE = SCALE_BITS'(1000);

   localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [TIMER_BITS-1:0]  timer_type;
   typedef logic [CFG_BITS-1:0]    cfg_type;
   typedef logic [LIMIT_BITS-1:0]  limit_type;
   typedef logic [1:0]             zone_type;
   typedef logic [1:0]             mode_type;
   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   localparam timer_type TIMER_MAX = {TIMER_BITS{1'b1}};
   localparam limit_type LIMIT_MAX = {LIMIT_BITS{1'b1}};

   // Zone codes
   localparam zone_type ZONE_NORMAL = 2'd0;
   localparam zone_type ZONE_HIGH   = 2'd1;
   localparam zone_type ZONE_LOW    = 2'd2;

   // Menu modes
   localparam mode_type MODE_DISPLAY = 2'd0;
   localparam mode_type MODE_UPPER   = 2'd1;
   localparam mode_type MODE_LOWER   = 2'd2;

   // Register indexes
   localparam csr_idx_type CSR_LOCKOUT = 2'd0;
   localparam csr_idx_type CSR_BLINK   = 2'd1;
   localparam csr_idx_type CSR_BUZZER  = 2'd2;

   // Reset values
   localparam cfg_type   LOCKOUT_RESET = CFG_BITS'(200);
   localparam cfg_type   BLINK_RESET   = CFG_BITS'(500);
   localparam cfg_type   BUZZER_RESET  = CFG_BITS'(300);
   localparam limit_type UPPER_RESET   = LIMIT_BITS'(60);
   localparam limit_type LOWER_RESET   = LIMIT_BITS'(40);

   // Saturating tick counter increment
   function automatic timer_type tick_up(input timer_type count);
      tick_up = (count == TIMER_MAX) ? count : count + timer_type'(1);
   endfunction

   // True once more ticks than the period have passed
   function automatic logic period_done(input timer_type count, input cfg_type period);
      period_done = CMP_BITS'(count) > CMP_BITS'(period);
   endfunction

   // Half-degree step, saturating; up and down together cancel
   function automatic limit_type step_limit(input limit_type value, input logic up,
                                            input logic down);
      limit_type result;
      result = value;
      if (up && !down && value != LIMIT_MAX) begin
         result = value + limit_type'(1);
      end else if (down && !up && value != limit_type'(0)) begin
         result = value - limit_type'(1);
      end
      step_limit = result;
   endfunction

endpackage

@@ hw/rtl/thermostat_zone_and_setpoint_menu.sv @@
// An accepted item waits in the input register; its result is registered in
// the result register when the item advances. Throughput: one item per cycle
// while results are taken; the input register and the result register advance
// together, so a stalled result holds the waiting item and the input.
// Reset (synchronous, active high) clears both valid flags, restores the three
// periods to 200/500/300 ticks, the limits to 60/40 half degrees, the menu to
// display, all tick counters to zero, blink visible and buzzer silent.
module thermostat_zone_and_setpoint_menu
   import tzsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_we,
   input  csr_idx_type csr_index,
   input  cfg_type     csr_wdata,

   input  logic        req_valid,
   output logic        req_ready,
   input  sample_type  req_sample,
   input  logic        req_press_up,
   input  logic        req_press_down,
   input  logic        req_press_enter,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output zone_type    rsp_zone,
   output logic        rsp_motor_on,
   output logic        rsp_buzzer_on,
   output mode_type    rsp_menu_mode,
   output logic        rsp_blink_visible,
   output limit_type   rsp_upper_limit,
   output limit_type   rsp_lower_limit,
   output logic        rsp_store_upper,
   output logic        rsp_store_lower
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   cfg_type lockout_ff, blink_period_ff, buzzer_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff       <= LOCKOUT_RESET;
         blink_period_ff  <= BLINK_RESET;
         buzzer_period_ff <= BUZZER_RESET;
      end else if (csr_we) begin
         // Unknown indexes fall through and are dropped
         if (csr_index == CSR_LOCKOUT) lockout_ff       <= csr_wdata;
         if (csr_index == CSR_BLINK)   blink_period_ff  <= csr_wdata;
         if (csr_index == CSR_BUZZER)  buzzer_period_ff <= csr_wdata;
      end
   end

   // ---------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------
   logic       in_valid_ff;
   sample_type sample_ff;
   logic       up_ff, down_ff, enter_ff;
   logic       advance;

   // The held item moves on when the result register is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         sample_ff <= req_sample;
         up_ff     <= req_press_up;
         down_ff   <= req_press_down;
         enter_ff  <= req_press_enter;
      end
   end

   // ---------------------------------------------------------------------
   // Thermostat state
   // ---------------------------------------------------------------------
   mode_type  mode_ff, mode_in;
   limit_type upper_ff, upper_in, lower_ff, lower_in;
   timer_type since_press_ff, since_press_in;
   timer_type since_blink_ff, since_blink_in;
   timer_type since_buzz_ff, since_buzz_in;
   logic      blink_ff, blink_in;
   logic      buzz_ff, buzz_in;

   // Per-item work
   logic [SCALED_BITS-1:0] scaled;
   logic [SCALED_BITS-1:0] upper_scaled, lower_scaled;
   zone_type  zone;
   timer_type press_tick, blink_tick, buzz_tick;
   logic      take_press, up_acc, down_acc, enter_acc;
   logic      store_upper, store_lower;

   always_comb begin
      // Exact compare in units of 1/(2*2^SAMPLE_BITS) degree
      scaled       = SCALED_BITS'(sample_ff) * SCALED_BITS'(SAMPLE_SCALE);
      upper_scaled = {upper_ff, SAMPLE_BITS'(0)};
      lower_scaled = {lower_ff, SAMPLE_BITS'(0)};

      if (scaled > upper_scaled) begin
         zone = ZONE_HIGH;
      end else if (scaled < lower_scaled) begin
         zone = ZONE_LOW;
      end else begin
         zone = ZONE_NORMAL;
      end

      press_tick = tick_up(since_press_ff);
      blink_tick = tick_up(since_blink_ff);
      buzz_tick  = tick_up(since_buzz_ff);

      // Buzzer toggles only while hot; the phase holds otherwise, but the count runs on
      buzz_in       = buzz_ff;
      since_buzz_in = buzz_tick;
      if (zone == ZONE_HIGH && period_done(buzz_tick, buzzer_period_ff)) begin
         buzz_in       = !buzz_ff;
         since_buzz_in = '0;
      end

      // Presses inside the lockout window are dropped
      take_press     = period_done(press_tick, lockout_ff);
      up_acc         = take_press && up_ff;
      down_acc       = take_press && down_ff;
      enter_acc      = take_press && enter_ff;
      since_press_in = (up_acc || down_acc || enter_acc) ? '0 : press_tick;

      blink_in       = blink_ff;
      since_blink_in = blink_tick;
      if (period_done(blink_tick, blink_period_ff)) begin
         blink_in       = !blink_ff;
         since_blink_in = '0;
      end

      // Menu
      mode_in     = mode_ff;
      upper_in    = upper_ff;
      lower_in    = lower_ff;
      store_upper = 1'b0;
      store_lower = 1'b0;
      unique case (mode_ff)
         MODE_UPPER: begin
            upper_in = step_limit(upper_ff, up_acc, down_acc);
            if (enter_acc) begin
               store_upper = 1'b1;
               mode_in     = MODE_LOWER;
            end
         end
         MODE_LOWER: begin
            lower_in = step_limit(lower_ff, up_acc, down_acc);
            if (enter_acc) begin
               store_lower = 1'b1;
               mode_in     = MODE_DISPLAY;
            end
         end
         default: begin
            // Display, and the unused fourth code, which acts as display
            mode_in = enter_acc ? MODE_UPPER : MODE_DISPLAY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_DISPLAY;
         upper_ff       <= UPPER_RESET;
         lower_ff       <= LOWER_RESET;
         since_press_ff <= '0;
         since_blink_ff <= '0;
         since_buzz_ff  <= '0;
         blink_ff       <= 1'b1;
         buzz_ff        <= 1'b0;
      end else if (advance) begin
         mode_ff        <= mode_in;
         upper_ff       <= upper_in;
         lower_ff       <= lower_in;
         since_press_ff <= since_press_in;
         since_blink_ff <= since_blink_in;
         since_buzz_ff  <= since_buzz_in;
         blink_ff       <= blink_in;
         buzz_ff        <= buzz_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   logic      out_valid_ff;
   zone_type  zone_ff;
   logic      buzzer_ff;
   mode_type  out_mode_ff;
   logic      out_blink_ff;
   limit_type out_upper_ff, out_lower_ff;
   logic      store_upper_ff, store_lower_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zone_ff        <= zone;
         buzzer_ff      <= (zone == ZONE_HIGH) && buzz_in;
         out_mode_ff    <= mode_in;
         out_blink_ff   <= blink_in;
         out_upper_ff   <= upper_in;
         out_lower_ff   <= lower_in;
         store_upper_ff <= store_upper;
         store_lower_ff <= store_lower;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_zone          = zone_ff;
   assign rsp_motor_on      = (zone_ff == ZONE_HIGH);
   assign rsp_buzzer_on     = buzzer_ff;
   assign rsp_menu_mode     = out_mode_ff;
   assign rsp_blink_visible = out_blink_ff;
   assign rsp_upper_limit   = out_upper_ff;
   assign rsp_lower_limit   = out_lower_ff;
   assign rsp_store_upper   = store_upper_ff;
   assign rsp_store_lower   = store_lower_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_limits_move_on_advance: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (!$stable(upper_ff) || !$stable(lower_ff))) |-> $past(advance))
      else $error("limit changed without an item moving");

   a_mode_moves_on_advance: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(mode_ff)) |-> $past(advance))
      else $error("menu mode changed without an item moving");

   a_store_upper_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_store_upper) |-> (rsp_menu_mode == MODE_LOWER))
      else $error("upper store strobe without move to lower setting");

   a_store_lower_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_store_lower) |-> (rsp_menu_mode == MODE_DISPLAY))
      else $error("lower store strobe without return to display");

   a_buzzer_needs_motor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_buzzer_on) |-> rsp_motor_on)
      else $error("buzzer on outside the high zone");

endmodule
